>>> rtl/core/legendre_poly_and_derivatives_core_macros.svh
// Assertion macros for the Legendre polynomial core
`ifndef LEGENDRE_POLY_AND_DERIVATIVES_CORE_MACROS_SVH
`define LEGENDRE_POLY_AND_DERIVATIVES_CORE_MACROS_SVH

// same-cycle implication
`define LPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/lpd_pkg.sv
// Shared types, constants and saturation helpers for the Legendre core
package lpd_pkg;

  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;

  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_GUARD  = 1'b1;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic        wide;   // mul: shift by 30, div: scale by 2^60
  } op_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } op_rsp_t;

  function automatic logic [63:0] mag(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] from_mag(input logic [63:0] m, input logic neg,
                                           input logic ovf);
    if (neg) begin
      if (ovf || m[63]) return SAT_MIN;
      return 64'd0 - m;
    end
    if (ovf || m[63]) return SAT_MAX;
    return m;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] d;
    d = {a[63], a} - {b[63], b};
    if (d[64] != d[63]) return d[64] ? SAT_MIN : SAT_MAX;
    return d[63:0];
  endfunction

endpackage

>>> rtl/core/legendre_poly_and_derivatives_core.sv
// Top level: sequencer driving the shared multiplier and divider
// An item is taken when start is high and busy is low; busy stays high until the
// result strobe out_valid, which lasts one cycle and cannot be held off. Degrees 0
// and 1 go straight to the result. For degree n >= 2 the recurrence runs twice (at x
// and at the nudged x), each step using three passes of the multiplier and one
// pass of the bit-serial divider.
`include "legendre_poly_and_derivatives_core_macros.svh"

module legendre_poly_and_derivatives_core #(
  parameter int MAX_DEGREE = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_point,
  output logic               out_valid,
  output logic signed [63:0] out_value,
  output logic signed [63:0] out_first_derivative,
  output logic signed [63:0] out_second_derivative,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [20:0]        cfg_wdata
);
  import lpd_pkg::*;

  localparam int NW  = $clog2(MAX_DEGREE + 1);
  localparam int NNW = 2 * NW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_RM1   = 4'd2;
  localparam logic [3:0] S_RM2   = 4'd3;
  localparam logic [3:0] S_RM3   = 4'd4;
  localparam logic [3:0] S_RDIV  = 4'd5;
  localparam logic [3:0] S_DEN   = 4'd6;
  localparam logic [3:0] S_D1M   = 4'd7;
  localparam logic [3:0] S_D1N   = 4'd8;
  localparam logic [3:0] S_D1DIV = 4'd9;
  localparam logic [3:0] S_D2M1  = 4'd10;
  localparam logic [3:0] S_D2M2  = 4'd11;
  localparam logic [3:0] S_D2M3  = 4'd12;
  localparam logic [3:0] S_D2DIV = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [5:0]     degree_r;
  logic [20:0]    guard_r;
  logic [3:0]     state_r;
  logic           wait_r, pass_r;
  logic [NW-1:0]  n_r, k_r;
  logic [NNW-1:0] nn1_r;
  logic [63:0]    xcur_r, prev_r, cur_r, tmp_r, val_r, den_r, d1_r;
  logic [63:0]    out_value_r, out_d1_r, out_d2_r;

  op_req_t mul_req, div_req;
  op_rsp_t mul_rsp, div_rsp;

  logic          is_op, is_div, go, rsp_done;
  logic [63:0]   op_a, op_b, rsp_res;
  logic          op_wide;
  logic [6:0]    n_clamp;
  logic [NW-1:0] n_in;
  logic [NW:0]   k2m1, n_p1;
  logic signed [35:0] xa, xb, xc, gs, dv1, dv2;

  always_comb begin
    n_clamp = ({1'b0, degree_r} > 7'(MAX_DEGREE)) ? 7'(MAX_DEGREE) : {1'b0, degree_r};
    n_in    = NW'(n_clamp);
    n_p1    = {1'b0, n_in} + (NW+1)'(1);
    k2m1    = {k_r, 1'b0} - (NW+1)'(1);
  end

  // endpoint nudge on the current point
  always_comb begin
    xa  = xcur_r[35:0];
    gs  = 36'(guard_r);
    dv1 = xa - 36'sh0_4000_0000;
    xb  = ((dv1 > -gs) && (dv1 < gs)) ? (xa - (gs <<< 1)) : xa;
    dv2 = xb + 36'sh0_4000_0000;
    xc  = ((dv2 > -gs) && (dv2 < gs)) ? (xb + (gs <<< 1)) : xb;
  end

  always_comb begin
    is_op   = 1'b1;
    is_div  = 1'b0;
    op_a    = tmp_r;
    op_b    = 64'd0;
    op_wide = 1'b0;
    unique case (state_r)
      S_RM1:   begin op_a = xcur_r; op_b = cur_r; op_wide = 1'b1; end
      S_RM2:   begin op_a = tmp_r; op_b = 64'(k2m1); end
      S_RM3:   begin op_a = prev_r; op_b = 64'(k_r - NW'(1)); end
      S_RDIV:  begin is_div = 1'b1; op_a = tmp_r; op_b = 64'(k_r); end
      S_DEN:   begin op_a = xcur_r; op_b = xcur_r; end
      S_D1M:   begin op_a = xcur_r; op_b = cur_r; op_wide = 1'b1; end
      S_D1N:   begin op_a = tmp_r; op_b = 64'(n_r); end
      S_D1DIV: begin is_div = 1'b1; op_a = tmp_r; op_b = den_r; op_wide = 1'b1; end
      S_D2M1:  begin op_a = xcur_r; op_b = d1_r; op_wide = 1'b1; end
      S_D2M2:  begin op_a = tmp_r; op_b = 64'd2; end
      S_D2M3:  begin op_a = cur_r; op_b = 64'(nn1_r); end
      S_D2DIV: begin
        is_div = 1'b1; op_a = tmp_r; op_b = 64'd0 - den_r; op_wide = 1'b1;
      end
      default: is_op = 1'b0;
    endcase
    go = is_op && !wait_r;
    mul_req.start = go && !is_div;
    mul_req.a     = op_a;
    mul_req.b     = op_b;
    mul_req.wide  = op_wide;
    div_req.start = go && is_div;
    div_req.a     = op_a;
    div_req.b     = op_b;
    div_req.wide  = op_wide;
    rsp_done = mul_rsp.done | div_rsp.done;
    rsp_res  = mul_rsp.done ? mul_rsp.res : div_rsp.res;
  end

  lpd_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  lpd_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= 6'd0;
      guard_r  <= 21'd16;
      state_r  <= S_IDLE;
      wait_r   <= 1'b0;
      pass_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEGREE: degree_r <= cfg_wdata[5:0];
          CFG_GUARD:  guard_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (go) wait_r <= 1'b1;
      if (rsp_done) wait_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            n_r    <= n_in;
            nn1_r  <= NNW'(n_in) * NNW'(n_p1);
            xcur_r <= {{32{in_point[31]}}, in_point};
            pass_r <= 1'b0;
            if (n_in == NW'(0)) begin
              out_value_r <= ONE_Q32;
              out_d1_r    <= 64'd0;
              out_d2_r    <= 64'd0;
              state_r     <= S_OUT;
            end else if (n_in == NW'(1)) begin
              out_value_r <= {{30{in_point[31]}}, in_point, 2'b00};
              out_d1_r    <= ONE_Q32;
              out_d2_r    <= 64'd0;
              state_r     <= S_OUT;
            end else begin
              state_r <= S_INIT;
            end
          end
        end
        S_INIT: begin
          prev_r  <= ONE_Q32;
          cur_r   <= {xcur_r[61:0], 2'b00};
          k_r     <= NW'(2);
          state_r <= S_RM1;
        end
        S_RM1: if (rsp_done) begin tmp_r <= rsp_res; state_r <= S_RM2; end
        S_RM2: if (rsp_done) begin tmp_r <= rsp_res; state_r <= S_RM3; end
        S_RM3: if (rsp_done) begin tmp_r <= sat_sub(tmp_r, rsp_res); state_r <= S_RDIV; end
        S_RDIV: begin
          if (rsp_done) begin
            prev_r <= cur_r;
            cur_r  <= rsp_res;
            if (k_r == n_r) begin
              if (!pass_r) begin
                val_r   <= rsp_res;
                xcur_r  <= {{28{xc[35]}}, xc};
                pass_r  <= 1'b1;
                state_r <= S_INIT;
              end else begin
                state_r <= S_DEN;
              end
            end else begin
              k_r     <= k_r + NW'(1);
              state_r <= S_RM1;
            end
          end
        end
        S_DEN:   if (rsp_done) begin den_r <= rsp_res - ONE_Q60; state_r <= S_D1M; end
        S_D1M:   if (rsp_done) begin tmp_r <= sat_sub(rsp_res, prev_r); state_r <= S_D1N; end
        S_D1N:   if (rsp_done) begin tmp_r <= rsp_res; state_r <= S_D1DIV; end
        S_D1DIV: if (rsp_done) begin d1_r <= rsp_res; state_r <= S_D2M1; end
        S_D2M1:  if (rsp_done) begin tmp_r <= rsp_res; state_r <= S_D2M2; end
        S_D2M2:  if (rsp_done) begin tmp_r <= rsp_res; state_r <= S_D2M3; end
        S_D2M3:  if (rsp_done) begin tmp_r <= sat_sub(tmp_r, rsp_res); state_r <= S_D2DIV; end
        S_D2DIV: begin
          if (rsp_done) begin
            out_value_r <= val_r;
            out_d1_r    <= d1_r;
            out_d2_r    <= rsp_res;
            state_r     <= S_OUT;
          end
        end
        S_OUT:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_OUT);
  assign out_value             = out_value_r;
  assign out_first_derivative  = out_d1_r;
  assign out_second_derivative = out_d2_r;

  `LPD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted but block not busy")
  `LPD_ASSERT_NEXT(a_out_once, out_valid, !out_valid && !busy, "result strobe not single")
  `LPD_ASSERT_NOW(a_unit_excl, mul_rsp.done, !div_rsp.done, "both units finished together")
  `LPD_ASSERT_NOW(a_idle_nowait, !busy, !wait_r, "idle with an operation pending")

endmodule

>>> rtl/core/lpd_mul.sv
// Sequential 64x64 signed multiplier, 32x32 partial products, shift and saturate
module lpd_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  lpd_pkg::op_req_t req,
  output lpd_pkg::op_rsp_t rsp
);
  import lpd_pkg::*;

  logic [63:0]  ua_r, ub_r, res_r;
  logic [127:0] acc_r;
  logic [1:0]   cnt_r;
  logic         neg_r, wide_r, run_r, fin_r, done_r;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [1:0]   sh;
  logic [127:0] acc_nxt;
  logic [63:0]  mres;
  logic         movf;

  always_comb begin
    ah = cnt_r[1] ? ua_r[63:32] : ua_r[31:0];
    bh = cnt_r[0] ? ub_r[63:32] : ub_r[31:0];
    pp = ah * bh;
    sh = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    acc_nxt = acc_r + ({64'd0, pp} << {sh, 5'b0});
    if (wide_r) begin
      mres = acc_r[93:30];
      movf = |acc_r[127:94];
    end else begin
      mres = acc_r[63:0];
      movf = |acc_r[127:64];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        ua_r   <= mag(req.a);
        ub_r   <= mag(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        wide_r <= req.wide;
        acc_r  <= 128'd0;
        cnt_r  <= 2'd0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= from_mag(mres, neg_r, movf);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

>>> rtl/core/lpd_div.sv
// Restoring divider, one quotient bit per cycle, optional 2^60 scaling, saturating
module lpd_div (
  input  logic            clk,
  input  logic            rst_n,
  input  lpd_pkg::op_req_t req,
  output lpd_pkg::op_rsp_t rsp
);
  import lpd_pkg::*;

  logic [127:0] d_r;
  logic [63:0]  ub_r, rem_r, q_r, res_r;
  logic [7:0]   cnt_r;
  logic         neg_r, ovf_r, run_r, fin_r, done_r;
  logic [63:0]  ua, ub;
  logic [64:0]  r2;
  logic         ge;
  logic [63:0]  rem_nxt;

  always_comb begin
    ua = mag(req.a);
    ub = mag(req.b);
    r2 = {rem_r, d_r[127]};
    ge = r2 >= {1'b0, ub_r};
    rem_nxt = ge ? (r2[63:0] - ub_r) : r2[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 8'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        neg_r <= req.a[63] ^ req.b[63];
        ub_r  <= ub;
        rem_r <= 64'd0;
        q_r   <= 64'd0;
        ovf_r <= 1'b0;
        if (ua == 64'd0) begin
          res_r  <= 64'd0;
          done_r <= 1'b1;
        end else if (ub == 64'd0) begin
          res_r  <= req.a[63] ? SAT_MIN : SAT_MAX;
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
          if (req.wide) begin
            d_r   <= {64'd0, ua} << 60;
            cnt_r <= 8'd128;
          end else begin
            d_r   <= {ua, 64'd0};
            cnt_r <= 8'd64;
          end
        end
      end else if (run_r) begin
        d_r   <= {d_r[126:0], 1'b0};
        rem_r <= rem_nxt;
        ovf_r <= ovf_r | q_r[63];
        q_r   <= {q_r[62:0], ge};
        cnt_r <= cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= from_mag(q_r, neg_r, ovf_r);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
